// ===== rtl/swm_pkg.sv =====
// Shared widths, defaults, ring entry type and controller/datapath interface structs.
package swm_pkg;

    // Field widths.
    localparam int SAMPLE_W = 32;
    localparam int STAMP_W  = 8;
    localparam int WLEN_W   = 8;

    // Defaults.
    localparam int           RING_DEPTH_DEF = 128;
    localparam logic [7:0]   WLEN_RESET     = 8'd3;

    // One ring entry: a stored minimum and the sample count at which it expires.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic [STAMP_W-1:0]         expiry;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;     // latch the accepted word and its expiry stamp
        logic first;       // first sample: ring becomes a single entry in slot 0
        logic replace;     // sample replaces the head and becomes the only entry
        logic head_adv;    // drop the expired head, read the next one
        logic load_cache;  // refresh the head copy from the read data
        logic walk_start;  // begin the tail walk at the tail
        logic walk_step;   // step the walk back by one entry
        logic append;      // write the sample after the tail, or where the walk stops
        logic app_walk;    // append position comes from the walk
        logic out_load;    // load the output register with the head value
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic started;
        logic expired;
        logic head_eq_tail;
        logic le_head;
        logic walk_lt;
        logic walk_prev_head;
        logic app_full;
        logic out_busy;
    } t_sts;

endpackage

// ===== rtl/swm_ctrl.sv =====
// Sequencer for one sample: expiry check, compare, tail walk and result hand-off.
module swm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_sample_valid,
    output logic          o_sample_stall,
    input  swm_pkg::t_sts i_sts,
    output swm_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_HLD  = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;
    localparam logic [2:0] S_FLD  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_sample_stall = (r_state != S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.app_walk = (r_state == S_WALK);
        case (r_state)
            S_IDLE: begin
                if (i_sample_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_CHK, S_CMP: begin
                if ((r_state == S_CHK) && !i_sts.started) begin
                    o_cmd.first = 1'b1;
                    n_state = S_OUT;
                end else if ((r_state == S_CHK) && i_sts.expired) begin
                    if (i_sts.head_eq_tail) begin
                        o_cmd.replace = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        o_cmd.head_adv = 1'b1;
                        n_state = S_HLD;
                    end
                end else if (i_sts.le_head) begin
                    o_cmd.replace = 1'b1;
                    n_state = S_OUT;
                end else if (i_sts.head_eq_tail) begin
                    o_cmd.append = 1'b1;
                    n_state = i_sts.app_full ? S_FLD : S_OUT;
                end else begin
                    o_cmd.walk_start = 1'b1;
                    n_state = S_WALK;
                end
            end
            S_HLD: begin
                o_cmd.load_cache = 1'b1;
                n_state = S_CMP;
            end
            S_WALK: begin
                if (i_sts.walk_lt || i_sts.walk_prev_head) begin
                    o_cmd.append = 1'b1;
                    n_state = i_sts.app_full ? S_FLD : S_OUT;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_FLD: begin
                o_cmd.load_cache = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/swm_dp.sv =====
// Datapath: ring memory, head copy, indices, sample counter and output register.
module swm_dp #(
    parameter int RING_DEPTH = swm_pkg::RING_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_cfg_valid,
    input  logic [swm_pkg::WLEN_W-1:0]          i_cfg_data,
    input  logic                                i_min_stall,
    output logic                                o_min_valid,
    output logic signed [swm_pkg::SAMPLE_W-1:0] o_window_min,
    input  swm_pkg::t_cmd                       i_cmd,
    output swm_pkg::t_sts                       o_sts
);

    localparam int              IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(RING_DEPTH - 1);
    localparam logic [31:0]      DEPTH32 = 32'(RING_DEPTH);

    swm_pkg::t_entry r_mem [RING_DEPTH];
    swm_pkg::t_entry r_rdata;
    swm_pkg::t_entry r_cache;
    swm_pkg::t_entry wr_data;

    logic signed [swm_pkg::SAMPLE_W-1:0] r_sample;
    logic [swm_pkg::STAMP_W-1:0]         r_stamp;
    logic [swm_pkg::STAMP_W-1:0]         r_count;
    logic [swm_pkg::WLEN_W-1:0]          r_wlen;
    logic [IDX_W-1:0]                    r_head;
    logic [IDX_W-1:0]                    r_tail;
    logic [IDX_W-1:0]                    r_t;
    logic                                r_started;
    logic                                r_out_valid;
    logic signed [swm_pkg::SAMPLE_W-1:0] r_out;

    logic [swm_pkg::WLEN_W-1:0] eff_len;
    logic [IDX_W-1:0]           head_next;
    logic [IDX_W-1:0]           tail_next;
    logic [IDX_W-1:0]           t_next;
    logic [IDX_W-1:0]           t_prev;
    logic [IDX_W-1:0]           app_pos;
    logic [IDX_W-1:0]           rd_addr;
    logic [IDX_W-1:0]           wr_addr;
    logic                       wr_en;
    logic                       walk_lt;

    // Ring neighbors.
    assign head_next = (r_head == LAST) ? '0 : r_head + 1'b1;
    assign tail_next = (r_tail == LAST) ? '0 : r_tail + 1'b1;
    assign t_next    = (r_t == LAST) ? '0 : r_t + 1'b1;
    assign t_prev    = (r_t == '0) ? LAST : r_t - 1'b1;

    // Effective window length: at least one, at most the ring depth.
    always_comb begin
        if (r_wlen == '0) begin
            eff_len = swm_pkg::WLEN_W'(1);
        end else if ({24'd0, r_wlen} > DEPTH32) begin
            eff_len = swm_pkg::WLEN_W'(RING_DEPTH);
        end else begin
            eff_len = r_wlen;
        end
    end

    // The entry just read by the walk lies below the sample.
    assign walk_lt = (r_rdata.value < r_sample);

    // The walk stops behind an entry below the sample, or at the entry after the head.
    assign app_pos = i_cmd.app_walk ? (walk_lt ? t_next : r_t) : tail_next;

    // Memory addresses and write data.
    always_comb begin
        wr_en = i_cmd.first | i_cmd.replace | i_cmd.append;
        if (i_cmd.first) begin
            wr_addr = '0;
        end else if (i_cmd.replace) begin
            wr_addr = r_head;
        end else begin
            wr_addr = app_pos;
        end
        wr_data.value  = r_sample;
        wr_data.expiry = r_stamp;
        if (i_cmd.walk_start) begin
            rd_addr = r_tail;
        end else if (i_cmd.walk_step) begin
            rd_addr = t_prev;
        end else begin
            rd_addr = head_next;
        end
    end

    // Ring memory with registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Status to the controller.
    always_comb begin
        o_sts.started        = r_started;
        o_sts.expired        = (r_cache.expiry == r_count);
        o_sts.head_eq_tail   = (r_head == r_tail);
        o_sts.le_head        = (r_sample <= r_cache.value);
        o_sts.walk_lt        = walk_lt;
        o_sts.walk_prev_head = (t_prev == r_head);
        o_sts.app_full       = (app_pos == r_head);
        o_sts.out_busy       = r_out_valid & i_min_stall;
    end

    // Input word, stamp, head copy, walk pointer and output value.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sample <= i_sample;
            r_stamp  <= r_count + eff_len;
        end
        if (i_cmd.first || i_cmd.replace) begin
            r_cache <= wr_data;
        end else if (i_cmd.load_cache) begin
            r_cache <= r_rdata;
        end
        if (i_cmd.walk_start) begin
            r_t <= r_tail;
        end else if (i_cmd.walk_step) begin
            r_t <= t_prev;
        end
        if (i_cmd.out_load) begin
            r_out <= r_cache.value;
        end
    end

    // Control state: indices, counter, start flag, window length and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_started   <= 1'b0;
            r_wlen      <= swm_pkg::WLEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_wlen <= i_cfg_data;
            end
            if (i_cmd.first) begin
                r_head    <= '0;
                r_tail    <= '0;
                r_started <= 1'b1;
            end else if (i_cmd.replace) begin
                r_tail <= r_head;
            end else if (i_cmd.head_adv) begin
                r_head <= head_next;
            end else if (i_cmd.append) begin
                r_tail <= app_pos;
                if (o_sts.app_full) begin
                    r_head <= head_next;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_count     <= r_count + 1'b1;
            end else if (!i_min_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_min_valid  = r_out_valid;
    assign o_window_min = r_out;

endmodule

// ===== rtl/sliding_window_minimum.sv =====
// Per sample the sequencer runs the check state, then the output state, which loads the
// output register once no held result is stalled. Dropping an expired head adds the reload
// and compare states, the tail walk the walk state, a full-ring append the fold state; no
// new sample is taken outside idle. The single ring read port walks one entry per cycle.
// Reset clears indices, sample counter, start flag and output valid, and sets the window
// length to 3; the ring memory is not cleared and no entry is used before it is written.
module sliding_window_minimum #(
    parameter int RING_DEPTH = swm_pkg::RING_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_sample_valid,
    output logic                                o_sample_stall,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                o_min_valid,
    input  logic                                i_min_stall,
    output logic signed [swm_pkg::SAMPLE_W-1:0] o_window_min,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [swm_pkg::WLEN_W-1:0]          i_cfg_data
);

    swm_pkg::t_cmd cmd;
    swm_pkg::t_sts sts;

    // The window length register takes a word in any cycle.
    assign o_cfg_ready = 1'b1;

    swm_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_stall (o_sample_stall),
        .i_sts          (sts),
        .o_cmd          (cmd)
    );

    swm_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample     (i_sample),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_min_stall  (i_min_stall),
        .o_min_valid  (o_min_valid),
        .o_window_min (o_window_min),
        .i_cmd        (cmd),
        .o_sts        (sts)
    );

    // An accepted word always occupies the sequencer in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample_valid && !o_sample_stall) |=> o_sample_stall)
        else $error("sequencer not busy after accepting a word");

    // At most one ring write per cycle.
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.first, cmd.replace, cmd.append}))
        else $error("conflicting ring writes");

    // A held result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !(o_min_valid && i_min_stall))
        else $error("output register overwritten while stalled");

    // The tail walk and the head advance only run on a ring that holds data.
    a_walk_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.walk_start || cmd.head_adv) |-> sts.started)
        else $error("ring access before the first sample");

endmodule
